@@ hw/rtl/partition_allocator_fit_macros.svh @@
// assertion macros for the partition allocator
`ifndef PARTITION_ALLOCATOR_FIT_MACROS_SVH
`define PARTITION_ALLOCATOR_FIT_MACROS_SVH

// implication checked on every clock edge outside reset
`define PAF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication outside reset
`define PAF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hw/rtl/paf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paf_pkg
// types, constants and codes shared by the partition allocator
// ----------------------------------------------------------------------------
package paf_pkg;
	localparam int MAX_SEGS  = 32;
	localparam int ADDR_BITS = 16;
	localparam int ID_BITS   = 8;
	localparam int IDX_BITS  = $clog2(MAX_SEGS);
	localparam int CNT_BITS  = $clog2(MAX_SEGS + 1);

	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [ID_BITS-1:0]   id_t;
	typedef logic [IDX_BITS-1:0]  idx_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NOSPACE  = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_FULL     = 3'd3,
		ST_BAD      = 3'd4
	} status_t;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [0:0] REG_FIT_MODE = 1'b0;
	localparam logic [0:0] REG_MEM_SIZE = 1'b1;

	localparam logic [15:0] MEM_SIZE_RESET = 16'd640;

	typedef struct packed {
		logic scan_clr;   // start a table scan
		logic scan_step;  // look at entry idx
		logic shift_up;   // copy entry idx-1 into idx
		logic shift_dn;   // copy entry idx+1 into idx
		logic put_rem;    // write remainder free entry at idx
		logic mark_busy;  // finish allocation at pick
		logic release_k;  // clear owner at pick
		logic merge_lo;   // add length of pick into pick-1
		logic merge_hi;   // add length of pick+1 into pick
		logic cnt_inc;
		logic cnt_dec;
		logic set_pick;   // pick <= pick-1
		idx_t idx;
	} dp_cmd_t;

	typedef struct packed {
		logic found;       // scan has a pick
		logic exact;       // picked length equals request
		logic full;        // table count at max
		logic prev_free;   // entry pick-1 exists and is free
		logic next_free;   // entry pick+1 exists and is free
		cnt_t count;
		idx_t pick;
	} dp_stat_t;
endpackage

@@ hw/rtl/partition_allocator_fit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partition_allocator_fit
// first-fit / best-fit segment allocator with split and coalesce
// ----------------------------------------------------------------------------
// channel  dir  fields
// s_axis   in   tdata: func, job_id, req_size
// m_axis   out  tdata: status, seg_start, seg_size
// cfg      in   0 fit_mode, 1 memory_size
//
// a request scans the table one entry at a time and then takes a decision; a
// split shifts the entries above the pick up once, a coalescing free shifts
// them down once per merge, and a request refused up front skips the scan;
// the table walk sets how long a request takes.
// reset and a memory_size write rebuild the table at once.
// a request is taken only when the result register is empty.
// ----------------------------------------------------------------------------
module partition_allocator_fit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // func, job_id, req_size, zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // status, seg_start, seg_size, zero pad
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import paf_pkg::*;
	`include "partition_allocator_fit_macros.svh"

	dp_cmd_t  cmd;
	dp_stat_t stat;
	addr_t    pick_base, pick_len;
	logic     idle, done, done_latch;
	status_t  done_status;
	logic     fit_q;
	logic     ovalid_q;
	status_t  ost_q;
	addr_t    ostart_q, osize_q;
	addr_t    lstart_q, llen_q;
	addr_t    rsize_q;
	logic     in_fire;

	assign s_axis_tready = idle;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	// fit mode configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fit_q <= 1'b0;
		else if (cfg_we && cfg_index == REG_FIT_MODE) fit_q <= cfg_data[0];
	end

	paf_ctrl u_ctrl (
		.clk, .arst_n, .in_fire,
		.in_func(s_axis_tdata[0]),
		.in_id(s_axis_tdata[8:1]),
		.in_size(s_axis_tdata[24:9]),
		.out_busy(ovalid_q),
		.stat, .cmd, .idle, .done, .done_status, .done_latch
	);

	paf_datapath u_dp (
		.clk, .arst_n,
		.cfg_init(cfg_we && cfg_index == REG_MEM_SIZE),
		.cfg_size(cfg_data),
		.fit_mode(fit_q),
		.req_load(in_fire),
		.req_free(s_axis_tdata[0]),
		.req_id(s_axis_tdata[8:1]),
		.req_size(s_axis_tdata[24:9]),
		.cmd, .stat, .pick_base, .pick_len
	);

	// requested size for the allocate result
	always_ff @(posedge clk) begin
		if (in_fire) rsize_q <= s_axis_tdata[24:9];
	end

	// segment snapshot before merging
	always_ff @(posedge clk) begin
		if (done_latch) begin
			lstart_q <= pick_base;
			llen_q   <= pick_len;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			ost_q    <= ST_OK;
		end else begin
			if (m_axis_tvalid && m_axis_tready) ovalid_q <= 1'b0;
			if (done) begin
				ovalid_q <= 1'b1;
				ost_q    <= done_status;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (done) begin
			if (done_status != ST_OK) begin
				ostart_q <= '0;
				osize_q  <= '0;
			end else if (cmd.mark_busy) begin
				ostart_q <= pick_base;
				osize_q  <= rsize_q;
			end else begin
				ostart_q <= lstart_q;
				osize_q  <= llen_q;
			end
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {5'd0, osize_q, ostart_q, ost_q};

	`PAF_ASSERT_IMP(a_ready_idle, clk, arst_n, s_axis_tready, !m_axis_tvalid)
	`PAF_ASSERT_NEXT(a_done_valid, clk, arst_n, done, m_axis_tvalid)
	`PAF_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1,
		stat.count != '0 && stat.count <= cnt_t'(MAX_SEGS))
endmodule

@@ hw/rtl/paf_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paf_datapath
// segment table registers, scan comparator and shift logic
// ----------------------------------------------------------------------------
module paf_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_init,
	input  logic [15:0]       cfg_size,
	input  logic              fit_mode,
	input  logic              req_load,
	input  logic              req_free,
	input  paf_pkg::id_t      req_id,
	input  paf_pkg::addr_t    req_size,
	input  paf_pkg::dp_cmd_t  cmd,
	output paf_pkg::dp_stat_t stat,
	output paf_pkg::addr_t    pick_base,
	output paf_pkg::addr_t    pick_len
);
	import paf_pkg::*;

	addr_t base_q [MAX_SEGS];
	addr_t len_q  [MAX_SEGS];
	id_t   own_q  [MAX_SEGS];
	logic  busy_q [MAX_SEGS];
	cnt_t  count_q;
	idx_t  pick_q;
	logic  found_q;
	logic  free_q;
	id_t   id_q;
	addr_t size_q;
	logic  fit_q;

	idx_t  pm1, pp1;
	logic  hit;
	assign pm1 = pick_q - idx_t'(1);
	assign pp1 = pick_q + idx_t'(1);

	// candidate test for the entry under scan
	always_comb begin
		if (free_q)
			hit = busy_q[cmd.idx] && own_q[cmd.idx] == id_q;
		else
			hit = !busy_q[cmd.idx] && len_q[cmd.idx] >= size_q &&
				(!found_q || (fit_q && len_q[cmd.idx] < len_q[pick_q]));
	end

	// request latch
	always_ff @(posedge clk) begin
		if (req_load) begin
			free_q <= req_free;
			id_q   <= req_id;
			size_q <= req_size;
			fit_q  <= fit_mode;
		end
	end

	// scan bookkeeping and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= cnt_t'(1);
			found_q <= 1'b0;
			pick_q  <= '0;
		end else if (cfg_init) begin
			count_q <= cnt_t'(1);
			found_q <= 1'b0;
		end else begin
			if (cmd.scan_clr) found_q <= 1'b0;
			if (cmd.scan_step && hit && !(free_q && found_q)) begin
				found_q <= 1'b1;
				pick_q  <= cmd.idx;
			end
			if (cmd.set_pick) pick_q <= pm1;
			if (cmd.cnt_inc)  count_q <= count_q + cnt_t'(1);
			if (cmd.cnt_dec)  count_q <= count_q - cnt_t'(1);
		end
	end

	// table storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SEGS; i++) begin
				busy_q[i] <= 1'b0;
				own_q[i]  <= '0;
			end
			base_q[0] <= '0;
			len_q[0]  <= addr_t'(MEM_SIZE_RESET);
		end else if (cfg_init) begin
			for (int i = 0; i < MAX_SEGS; i++) begin
				busy_q[i] <= 1'b0;
				own_q[i]  <= '0;
			end
			base_q[0] <= '0;
			len_q[0]  <= addr_t'(cfg_size);
		end else begin
			if (cmd.shift_up) begin
				base_q[cmd.idx] <= base_q[cmd.idx - idx_t'(1)];
				len_q[cmd.idx]  <= len_q[cmd.idx - idx_t'(1)];
				own_q[cmd.idx]  <= own_q[cmd.idx - idx_t'(1)];
				busy_q[cmd.idx] <= busy_q[cmd.idx - idx_t'(1)];
			end
			if (cmd.shift_dn) begin
				base_q[cmd.idx] <= base_q[cmd.idx + idx_t'(1)];
				len_q[cmd.idx]  <= len_q[cmd.idx + idx_t'(1)];
				own_q[cmd.idx]  <= own_q[cmd.idx + idx_t'(1)];
				busy_q[cmd.idx] <= busy_q[cmd.idx + idx_t'(1)];
			end
			if (cmd.put_rem) begin
				base_q[cmd.idx] <= base_q[pick_q] + size_q;
				len_q[cmd.idx]  <= len_q[pick_q] - size_q;
				own_q[cmd.idx]  <= '0;
				busy_q[cmd.idx] <= 1'b0;
			end
			if (cmd.mark_busy) begin
				len_q[pick_q]  <= size_q;
				busy_q[pick_q] <= 1'b1;
				own_q[pick_q]  <= id_q;
			end
			if (cmd.release_k) begin
				busy_q[pick_q] <= 1'b0;
				own_q[pick_q]  <= '0;
			end
			if (cmd.merge_lo) len_q[pm1] <= len_q[pm1] + len_q[pick_q];
			if (cmd.merge_hi) len_q[pick_q] <= len_q[pick_q] + len_q[pp1];
		end
	end

	// status back to the controller
	always_comb begin
		stat.found     = found_q;
		stat.exact     = len_q[pick_q] == size_q;
		stat.full      = count_q >= cnt_t'(MAX_SEGS);
		stat.prev_free = pick_q != '0 && !busy_q[pm1];
		stat.next_free = (CNT_BITS'(pick_q) + cnt_t'(1)) < count_q && !busy_q[pp1];
		stat.count     = count_q;
		stat.pick      = pick_q;
	end
	assign pick_base = base_q[pick_q];
	assign pick_len  = len_q[pick_q];
endmodule

@@ hw/rtl/paf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paf_ctrl
// request sequencer: scan, split or merge, then result
// ----------------------------------------------------------------------------
module paf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              in_func,
	input  paf_pkg::id_t      in_id,
	input  paf_pkg::addr_t    in_size,
	input  logic              out_busy,
	input  paf_pkg::dp_stat_t stat,
	output paf_pkg::dp_cmd_t  cmd,
	output logic              idle,
	output logic              done,
	output paf_pkg::status_t  done_status,
	output logic              done_latch
);
	import paf_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_SCAN  = 10'b0000000010,
		S_DEC   = 10'b0000000100,
		S_SHUP  = 10'b0000001000,
		S_REM   = 10'b0000010000,
		S_MARK  = 10'b0000100000,
		S_REL   = 10'b0001000000,
		S_MLO   = 10'b0010000000,
		S_SHDN  = 10'b0100000000,
		S_MHI   = 10'b1000000000
	} state_t;

	state_t  state_q;
	idx_t    idx_q;
	logic    free_q;
	logic    hi_q;
	status_t st_q;
	logic    fin;
	logic    last;

	assign last = (CNT_BITS'(idx_q) + cnt_t'(1)) >= stat.count;

	// next state, table index and request status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			free_q  <= 1'b0;
			hi_q    <= 1'b0;
			st_q    <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						idx_q  <= '0;
						free_q <= in_func;
						if (in_id == '0 || (in_func == FUNC_ALLOC && in_size == '0)) begin
							st_q    <= ST_BAD;
							state_q <= S_DEC;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + idx_t'(1);
					if (last) begin
						state_q <= S_DEC;
						st_q    <= ST_OK;
					end
				end
				S_DEC: begin
					if (st_q == ST_BAD) begin
						state_q <= S_IDLE;
					end else if (!stat.found) begin
						st_q    <= free_q ? ST_NOTFOUND : ST_NOSPACE;
						state_q <= S_IDLE;
					end else if (free_q) begin
						state_q <= S_REL;
					end else if (stat.exact) begin
						state_q <= S_MARK;
					end else if (stat.full) begin
						st_q    <= ST_FULL;
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_t'(stat.count);
						state_q <= (idx_t'(stat.count) == stat.pick + idx_t'(1)) ?
							S_REM : S_SHUP;
					end
				end
				S_SHUP: begin
					idx_q <= idx_q - idx_t'(1);
					if (idx_q - idx_t'(1) == stat.pick + idx_t'(1)) state_q <= S_REM;
				end
				S_REM:  state_q <= S_MARK;
				S_MARK: state_q <= S_IDLE;
				S_REL:  state_q <= stat.prev_free ? S_MLO : S_MHI;
				S_MLO: begin
					hi_q    <= 1'b0;
					idx_q   <= stat.pick;
					state_q <= S_SHDN;
				end
				S_MHI: begin
					if (stat.next_free) begin
						hi_q    <= 1'b1;
						idx_q   <= stat.pick + idx_t'(1);
						state_q <= S_SHDN;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SHDN: begin
					idx_q <= idx_q + idx_t'(1);
					if ((CNT_BITS'(idx_q) + cnt_t'(2)) >= stat.count)
						state_q <= hi_q ? S_IDLE : S_MHI;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result goes out when the sequence ends
	always_comb begin
		fin = 1'b0;
		unique case (state_q)
			S_DEC:  fin = st_q == ST_BAD || !stat.found || (!free_q && !stat.exact && stat.full);
			S_MARK: fin = 1'b1;
			S_MHI:  fin = !stat.next_free;
			S_SHDN: fin = hi_q && (CNT_BITS'(idx_q) + cnt_t'(2)) >= stat.count;
			default: fin = 1'b0;
		endcase
	end

	// command decode
	always_comb begin
		cmd = '0;
		cmd.idx = idx_q;
		cmd.scan_clr  = state_q == S_IDLE && in_fire;
		cmd.scan_step = state_q == S_SCAN;
		cmd.shift_up  = state_q == S_SHUP;
		cmd.put_rem   = state_q == S_REM;
		cmd.cnt_inc   = state_q == S_REM;
		cmd.mark_busy = state_q == S_MARK;
		cmd.release_k = state_q == S_REL;
		cmd.merge_lo  = state_q == S_MLO;
		cmd.set_pick  = state_q == S_MLO;
		cmd.merge_hi  = state_q == S_MHI && stat.next_free;
		cmd.shift_dn  = state_q == S_SHDN;
		cmd.cnt_dec   = state_q == S_SHDN && (CNT_BITS'(idx_q) + cnt_t'(2)) >= stat.count;
	end

	// free results report the segment before merging: latch at release
	assign done_latch  = (state_q == S_REL) || (state_q == S_MARK);
	assign done        = fin;
	assign done_status = (state_q == S_DEC) ?
		((st_q == ST_BAD) ? ST_BAD : !stat.found ? (free_q ? ST_NOTFOUND : ST_NOSPACE)
			: ST_FULL) : ST_OK;
	assign idle        = state_q == S_IDLE && !out_busy;
endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the first-fit / best-fit partition allocator
// ----------------------------------------------------------------------------
// A local copy of the segment table predicts every allocate and free request.
// Each result word is checked in order against the queue of predicted
// results. The run has these parts:
//   - directed cases: bad requests, splits, coalescing, duplicate owners,
//     a full table, and the memory size extremes
//   - random phases that change the fit mode and the memory size
//   - a long receiver hold-off
//   - a final part with no idling on either side
// ----------------------------------------------------------------------------
module tb_top;
	import paf_pkg::*;

	typedef struct {
		status_t st;
		addr_t   start;
		addr_t   size;
	} seg_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // func, job_id, req_size, zero pad
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;   // status, seg_start, seg_size, zero pad
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [15:0] cfg_data;

	// local copy of the allocator state
	logic        mdl_mode;
	addr_t       mdl_mem;
	addr_t       mdl_base [MAX_SEGS];
	addr_t       mdl_len  [MAX_SEGS];
	id_t         mdl_owner[MAX_SEGS];
	logic        mdl_busy [MAX_SEGS];
	int          mdl_count;

	seg_result_t expected_q[$];
	int          n_errors;
	int          n_sent;
	int          n_checked;
	int          n_full_seen;
	int          n_merge_seen;
	bit          quiet;
	int          hold_cycles;

	partition_allocator_fit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// overall time limit
	initial begin
		#40ms;
		$display("== FAIL ==");
		$finish;
	end

	// expected result queue access
	function automatic void exp_put(seg_result_t r);
		expected_q.insert(expected_q.size(), r);
	endfunction

	function automatic seg_result_t exp_take();
		seg_result_t r;
		r = expected_q[0];
		expected_q.delete(0);
		return r;
	endfunction

	// rebuild the table as one free segment
	function automatic void table_clear();
		for (int k = 0; k < MAX_SEGS; k++) begin
			mdl_base[k]  = '0;
			mdl_len[k]   = '0;
			mdl_owner[k] = '0;
			mdl_busy[k]  = 1'b0;
		end
		mdl_len[0] = mdl_mem;
		mdl_count  = 1;
	endfunction

	function automatic void drop_entry(int idx);
		for (int k = idx; k + 1 < mdl_count; k++) begin
			mdl_base[k]  = mdl_base[k+1];
			mdl_len[k]   = mdl_len[k+1];
			mdl_owner[k] = mdl_owner[k+1];
			mdl_busy[k]  = mdl_busy[k+1];
		end
		mdl_count--;
	endfunction

	// work out the result of one request and update the table
	function automatic seg_result_t predict_request(logic func, id_t id, addr_t req);
		seg_result_t r;
		int pick;
		int k;
		r.st    = ST_OK;
		r.start = '0;
		r.size  = '0;
		pick    = -1;
		if (id == '0 || (func == FUNC_ALLOC && req == '0)) begin
			r.st = ST_BAD;
		end else if (func == FUNC_ALLOC) begin
			for (k = 0; k < mdl_count; k++) begin
				if (mdl_busy[k] || mdl_len[k] < req) continue;
				if (pick < 0) begin
					pick = k;
					if (!mdl_mode) break;
				end else if (mdl_len[k] < mdl_len[pick]) begin
					pick = k;
				end
			end
			if (pick < 0) begin
				r.st = ST_NOSPACE;
			end else if (mdl_len[pick] > req && mdl_count >= MAX_SEGS) begin
				r.st = ST_FULL;
				n_full_seen++;
			end else begin
				if (mdl_len[pick] > req) begin
					// remainder goes into a new free entry after the pick
					for (k = mdl_count; k > pick + 1; k--) begin
						mdl_base[k]  = mdl_base[k-1];
						mdl_len[k]   = mdl_len[k-1];
						mdl_owner[k] = mdl_owner[k-1];
						mdl_busy[k]  = mdl_busy[k-1];
					end
					mdl_base[pick+1]  = mdl_base[pick] + req;
					mdl_len[pick+1]   = mdl_len[pick] - req;
					mdl_owner[pick+1] = '0;
					mdl_busy[pick+1]  = 1'b0;
					mdl_count++;
					mdl_len[pick] = req;
				end
				mdl_busy[pick]  = 1'b1;
				mdl_owner[pick] = id;
				r.start = mdl_base[pick];
				r.size  = req;
			end
		end else begin
			for (k = 0; k < mdl_count; k++)
				if (mdl_busy[k] && mdl_owner[k] == id) break;
			if (k >= mdl_count) begin
				r.st = ST_NOTFOUND;
			end else begin
				r.start      = mdl_base[k];
				r.size       = mdl_len[k];
				mdl_busy[k]  = 1'b0;
				mdl_owner[k] = '0;
				// coalesce with free neighbours
				if (k > 0 && !mdl_busy[k-1]) begin
					mdl_len[k-1] = mdl_len[k-1] + mdl_len[k];
					drop_entry(k);
					k--;
					n_merge_seen++;
				end
				if (k + 1 < mdl_count && !mdl_busy[k+1]) begin
					mdl_len[k] = mdl_len[k] + mdl_len[k+1];
					drop_entry(k + 1);
					n_merge_seen++;
				end
			end
		end
		return r;
	endfunction

	// send one request word, with a random gap in front of it
	task automatic send_req(logic func, id_t id, addr_t req);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 19);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		exp_put(predict_request(func, id, req));
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, req, id, func};
		n_sent++;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// wait for all results, then write one register
	task automatic write_reg(logic [0:0] index, logic [15:0] value);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == REG_FIT_MODE) begin
			mdl_mode = value[0];
		end else begin
			mdl_mem = value;
			table_clear();
		end
	endtask

	// result side: random stalls, long hold-off on request, in-order check
	always @(posedge clk or negedge arst_n) begin
		seg_result_t e;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_q.size() == 0) begin
					$error("result word with nothing expected: %h", m_axis_tdata);
					n_errors++;
				end else begin
					e = exp_take();
					n_checked++;
					if (m_axis_tdata[2:0] != e.st) begin
						$error("status expected %0d actual %0d", e.st, m_axis_tdata[2:0]);
						n_errors++;
					end
					if (m_axis_tdata[18:3] != e.start) begin
						$error("seg_start expected %0d actual %0d", e.start,
							m_axis_tdata[18:3]);
						n_errors++;
					end
					if (m_axis_tdata[34:19] != e.size) begin
						$error("seg_size expected %0d actual %0d", e.size,
							m_axis_tdata[34:19]);
						n_errors++;
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_axis_tready <= 1'b0;
			end else if (quiet) begin
				m_axis_tready <= 1'b1;
			end else if (!m_axis_tready) begin
				m_axis_tready <= ($urandom_range(0, 4) == 0);
			end else begin
				m_axis_tready <= ($urandom_range(0, 9) != 0);
			end
		end
	end

	// bad requests, split, coalesce, duplicate owner, best fit
	task automatic test_directed();
		send_req(FUNC_ALLOC, 8'd0, 16'd10);
		send_req(FUNC_FREE, 8'd0, 16'd0);
		send_req(FUNC_ALLOC, 8'd9, 16'd0);
		send_req(FUNC_ALLOC, 8'd9, 16'hFFFF);
		send_req(FUNC_FREE, 8'd77, 16'd5);
		send_req(FUNC_ALLOC, 8'd255, 16'd100);
		send_req(FUNC_ALLOC, 8'd5, 16'd50);
		send_req(FUNC_ALLOC, 8'd5, 16'd30);
		send_req(FUNC_ALLOC, 8'd6, 16'd100);
		send_req(FUNC_ALLOC, 8'd7, 16'd30);
		send_req(FUNC_FREE, 8'd5, 16'hFFFF);
		send_req(FUNC_FREE, 8'd7, 16'd0);
		write_reg(REG_FIT_MODE, 16'd1);
		// holes of 50 and the tail; best fit picks the smallest
		send_req(FUNC_ALLOC, 8'd8, 16'd20);
		send_req(FUNC_ALLOC, 8'd8, 16'd30);
		send_req(FUNC_FREE, 8'd6, 16'd0);
		send_req(FUNC_FREE, 8'd5, 16'd0);
		send_req(FUNC_FREE, 8'd8, 16'd0);
		send_req(FUNC_FREE, 8'd8, 16'd0);
		send_req(FUNC_FREE, 8'd255, 16'd0);
		send_req(FUNC_ALLOC, 8'd1, 16'd640);
		send_req(FUNC_FREE, 8'd1, 16'd0);
	endtask

	// fill the table, then split fails while an exact fit works
	task automatic test_table_full();
		write_reg(REG_FIT_MODE, 16'd0);
		write_reg(REG_MEM_SIZE, 16'd40);
		for (int i = 1; i < MAX_SEGS; i++) send_req(FUNC_ALLOC, id_t'(i), 16'd1);
		send_req(FUNC_ALLOC, 8'd200, 16'd2);
		send_req(FUNC_ALLOC, 8'd200, 16'd9);
		for (int i = 1; i < MAX_SEGS; i += 2) send_req(FUNC_FREE, id_t'(i), 16'd0);
		send_req(FUNC_FREE, 8'd200, 16'd0);
	endtask

	// zero, one and largest memory sizes
	task automatic test_mem_extremes();
		write_reg(REG_MEM_SIZE, 16'd0);
		send_req(FUNC_ALLOC, 8'd3, 16'd1);
		write_reg(REG_MEM_SIZE, 16'd1);
		send_req(FUNC_ALLOC, 8'd3, 16'd2);
		send_req(FUNC_ALLOC, 8'd3, 16'd1);
		write_reg(REG_MEM_SIZE, 16'hFFFF);
		send_req(FUNC_ALLOC, 8'd170, 16'hFFFF);
		send_req(FUNC_FREE, 8'd170, 16'd0);
		send_req(FUNC_ALLOC, 8'd85, 16'h5555);
		send_req(FUNC_ALLOC, 8'd86, 16'hAAAA);
	endtask

	// one random request, mostly well formed
	task automatic random_req();
		int dice;
		int k;
		addr_t sz;
		dice = $urandom_range(0, 99);
		if (dice < 55) begin
			sz = (mdl_mem < 16) ? 16'd1 : addr_t'($urandom_range(1, mdl_mem / 8));
			send_req(FUNC_ALLOC, id_t'($urandom_range(1, 255)), sz);
		end else if (dice < 88) begin
			// release the owner of some busy segment if there is one
			k = $urandom_range(0, mdl_count - 1);
			if (mdl_busy[k]) send_req(FUNC_FREE, mdl_owner[k], addr_t'($urandom));
			else send_req(FUNC_FREE, id_t'($urandom_range(1, 255)), addr_t'($urandom));
		end else if (dice < 92) begin
			send_req(FUNC_ALLOC, id_t'($urandom_range(1, 255)), addr_t'($urandom));
		end else if (dice < 96) begin
			send_req(logic'($urandom), 8'd0, addr_t'($urandom));
		end else begin
			send_req(FUNC_ALLOC, id_t'($urandom_range(1, 255)), 16'd0);
		end
	endtask

	// random phases over several settings
	task automatic test_random(int phases, int per_phase);
		addr_t mem;
		for (int p = 0; p < phases; p++) begin
			write_reg(REG_FIT_MODE, 16'($urandom_range(0, 1)));
			case ($urandom_range(0, 5))
				0: mem = 16'hFFFF;
				1: mem = addr_t'($urandom_range(1, 65535));
				default: mem = addr_t'($urandom_range(32, 2000));
			endcase
			write_reg(REG_MEM_SIZE, mem);
			for (int i = 0; i < per_phase; i++) random_req();
		end
	endtask

	// receiver holds off while requests keep coming
	task automatic test_backpressure();
		hold_cycles = 600;
		for (int i = 0; i < 20; i++) random_req();
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		n_errors      = 0;
		n_sent        = 0;
		n_checked     = 0;
		n_full_seen   = 0;
		n_merge_seen  = 0;
		quiet         = 1'b0;
		hold_cycles   = 0;
		mdl_mode      = 1'b0;
		mdl_mem       = MEM_SIZE_RESET;
		table_clear();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_table_full();
		test_mem_extremes();
		test_random(12, 140);
		test_backpressure();
		quiet = 1'b1;
		test_random(1, 100);

		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("%0d requests sent, %0d results checked, both fit modes", n_sent, n_checked);
		$display("%0d table-full refusals, %0d coalescing steps seen", n_full_seen,
			n_merge_seen);
		if (n_errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/paf_pkg.sv
hw/rtl/paf_datapath.sv
hw/rtl/paf_ctrl.sv
hw/rtl/partition_allocator_fit.sv
sim/tb_top.sv
